// ===== rtl/mcpa_pkg.sv =====
// Shared types and constants for the cross-product accumulator.
// Holds the input and result transfer structs and the element selectors.
// No dependencies.
package mcpa_pkg;

    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int VALUE_W = 48;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 3;

    localparam logic [CFG_W-1:0] CFG_COLS_RESET = 3'd4;

    // Column codes for the element selectors
    localparam logic [IDX_W-1:0] COL_0 = 2'd0;
    localparam logic [IDX_W-1:0] COL_1 = 2'd1;
    localparam logic [IDX_W-1:0] COL_2 = 2'd2;
    localparam logic [IDX_W-1:0] COL_3 = 2'd3;

    typedef struct packed {
        logic signed [ELEM_W-1:0] x_0;
        logic signed [ELEM_W-1:0] x_1;
        logic signed [ELEM_W-1:0] x_2;
        logic signed [ELEM_W-1:0] x_3;
        logic signed [ELEM_W-1:0] y_0;
        logic signed [ELEM_W-1:0] y_1;
        logic signed [ELEM_W-1:0] y_2;
        logic signed [ELEM_W-1:0] y_3;
        logic                     last_row;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [IDX_W-1:0]          out_row;
        logic [IDX_W-1:0]          out_col;
        logic                      last;
    } t_out_item;

    // Per-stage control carried down the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

    function automatic logic signed [ELEM_W-1:0] x_elem(t_in_item it, logic [IDX_W-1:0] k);
        logic signed [ELEM_W-1:0] r;
        unique case (k)
            COL_0: r = it.x_0;
            COL_1: r = it.x_1;
            COL_2: r = it.x_2;
            COL_3: r = it.x_3;
        endcase
        return r;
    endfunction

    function automatic logic signed [ELEM_W-1:0] y_elem(t_in_item it, logic [IDX_W-1:0] k);
        logic signed [ELEM_W-1:0] r;
        unique case (k)
            COL_0: r = it.y_0;
            COL_1: r = it.y_1;
            COL_2: r = it.y_2;
            COL_3: r = it.y_3;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/mcpa_mul.sv =====
// Input register and outer-product multiplier stage.
// Registers one row pair, then registers all COLS x COLS products.
// Depends on mcpa_pkg.
module mcpa_mul
    import mcpa_pkg::*;
#(
    parameter int COLS = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_in_valid,
    input  t_in_item                 i_in_item,
    output t_stage_ctl               o_ctl,
    output logic signed [PROD_W-1:0] o_prod [COLS][COLS]
);

    t_stage_ctl               r_a_ctl;
    t_in_item                 r_a_item;
    t_stage_ctl               r_b_ctl;
    logic signed [PROD_W-1:0] r_prod [COLS][COLS];
    logic signed [PROD_W-1:0] n_prod [COLS][COLS];

    // Stage control: advance only when the pipe is enabled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= '{valid: i_in_valid, last: i_in_item.last_row};
            r_b_ctl <= r_a_ctl;
        end
    end

    // Capture the row pair on transfer
    always_ff @(posedge i_clk) begin
        if (i_en && i_in_valid) begin
            r_a_item <= i_in_item;
        end
    end

    // One multiplier per accumulator cell
    for (genvar i = 0; i < COLS; i++) begin : g_row
        for (genvar j = 0; j < COLS; j++) begin : g_col
            assign n_prod[i][j] = x_elem(r_a_item, IDX_W'(i)) * y_elem(r_a_item, IDX_W'(j));

            always_ff @(posedge i_clk) begin
                if (i_en && r_a_ctl.valid) begin
                    r_prod[i][j] <= n_prod[i][j];
                end
            end

            assign o_prod[i][j] = r_prod[i][j];
        end
    end

    assign o_ctl = r_b_ctl;

endmodule

// ===== rtl/mcpa_acc.sv =====
// Saturating accumulator array for the cross-product sums.
// Adds each registered product into its cell and clears all cells on the last row.
// Depends on mcpa_pkg.
module mcpa_acc
    import mcpa_pkg::*;
#(
    parameter int COLS      = 4,
    parameter int ACC_WIDTH = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  t_stage_ctl                  i_ctl,
    input  logic signed [PROD_W-1:0]    i_prod [COLS][COLS],
    output logic signed [ACC_WIDTH-1:0] o_sum  [COLS][COLS]
);

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic signed [ACC_WIDTH-1:0] r_acc [COLS][COLS];

    for (genvar i = 0; i < COLS; i++) begin : g_row
        for (genvar j = 0; j < COLS; j++) begin : g_col
            logic signed [ACC_WIDTH:0] wide_sum;

            // Add with one guard bit, clamp when the guard disagrees with the sign
            assign wide_sum = (ACC_WIDTH+1)'(r_acc[i][j]) + (ACC_WIDTH+1)'(i_prod[i][j]);

            always_comb begin
                if (wide_sum[ACC_WIDTH] != wide_sum[ACC_WIDTH-1]) begin
                    o_sum[i][j] = wide_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
                end else begin
                    o_sum[i][j] = wide_sum[ACC_WIDTH-1:0];
                end
            end

            // Hold, accumulate, or clear after the last row
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_acc[i][j] <= '0;
                end else if (i_en && i_ctl.valid) begin
                    r_acc[i][j] <= i_ctl.last ? '0 : o_sum[i][j];
                end
            end
        end
    end

endmodule

// ===== rtl/mcpa_emit.sv =====
// Result snapshot buffer and row-major result sequencer with output register.
// Takes the final sums of one matrix and drains the used cells in order.
// Depends on mcpa_pkg.
module mcpa_emit
    import mcpa_pkg::*;
#(
    parameter int COLS      = 4,
    parameter int ACC_WIDTH = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [CFG_W-1:0]            i_cols_in_use,
    input  logic signed [ACC_WIDTH-1:0] i_sum [COLS][COLS],
    input  logic                        i_out_ready,
    output logic                        o_busy,
    output logic                        o_out_valid,
    output t_out_item                   o_out_item
);

    localparam int SEL_W = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int EXT_W = (ACC_WIDTH > VALUE_W) ? ACC_WIDTH : VALUE_W;

    logic signed [ACC_WIDTH-1:0] r_snap [COLS][COLS];
    logic                        r_busy;
    logic [IDX_W-1:0]            r_i;
    logic [IDX_W-1:0]            r_j;
    logic [IDX_W-1:0]            r_nm1;
    logic [IDX_W-1:0]            n_nm1;
    logic                        r_out_valid;
    t_out_item                   r_out_item;
    logic                        out_take;
    logic                        at_end_col;
    logic                        at_end_row;
    logic signed [EXT_W-1:0]     sel_ext;

    // Clamp the column count to 1..COLS and keep it as the last index
    always_comb begin
        if (i_cols_in_use == '0) begin
            n_nm1 = '0;
        end else if (32'(i_cols_in_use) > COLS) begin
            n_nm1 = IDX_W'(COLS - 1);
        end else begin
            n_nm1 = IDX_W'(i_cols_in_use - CFG_W'(1));
        end
    end

    assign out_take   = r_busy && (!r_out_valid || i_out_ready);
    assign at_end_col = (r_j == r_nm1);
    assign at_end_row = (r_i == r_nm1);

    // Snapshot the final sums of the matrix
    for (genvar i = 0; i < COLS; i++) begin : g_row
        for (genvar j = 0; j < COLS; j++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (i_load) begin
                    r_snap[i][j] <= i_sum[i][j];
                end
            end
        end
    end

    // Walk the used cells row by row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
            r_j    <= '0;
            r_nm1  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_i    <= '0;
            r_j    <= '0;
            r_nm1  <= n_nm1;
        end else if (out_take) begin
            if (at_end_col) begin
                r_j <= '0;
                if (at_end_row) begin
                    r_busy <= 1'b0;
                end else begin
                    r_i <= r_i + IDX_W'(1);
                end
            end else begin
                r_j <= r_j + IDX_W'(1);
            end
        end
    end

    // Low result bits of the selected cell, sign-extended for narrow accumulators
    assign sel_ext = EXT_W'(r_snap[r_i[SEL_W-1:0]][r_j[SEL_W-1:0]]);

    // Output register: load on take, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out_item.value   <= sel_ext[VALUE_W-1:0];
            r_out_item.out_row <= r_i;
            r_out_item.out_col <= r_j;
            r_out_item.last    <= at_end_col && at_end_row;
        end
    end

    assign o_busy      = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_final_on_diagonal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.last) |-> (o_out_item.out_row == o_out_item.out_col))
        else $error("final result not on the diagonal");

    a_start_at_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> (r_i == '0 && r_j == '0))
        else $error("sequencer did not start at cell zero");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_i <= r_nm1 && r_j <= r_nm1))
        else $error("sequencer index beyond used columns");

endmodule

// ===== rtl/matrix_cross_product_accumulator.sv =====
// Top level of the cross-product accumulator Z = transpose(X) * Y.
// Instantiates mcpa_mul, mcpa_acc and mcpa_emit; uses mcpa_pkg.
//
// One row pair of X and Y is taken per cycle. Each row passes an input register, a
// register of the COLS x COLS products, and then the saturating accumulator array.
// On a row marked last_row the finished sums are copied to a snapshot buffer and the
// accumulators clear, so the next matrix can stream in at once. The buffer delivers
// n*n results (n = clamped cols_in_use) through the output register, one per cycle
// while the receiver is ready. A further last row stalls input until the buffer has
// drained.
module matrix_cross_product_accumulator
    import mcpa_pkg::*;
#(
    parameter int COLS      = 4,
    parameter int ACC_WIDTH = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    logic [CFG_W-1:0]            r_cols_in_use;
    logic                        pipe_en;
    logic                        snap_load;
    logic                        emit_busy;
    t_stage_ctl                  prod_ctl;
    logic signed [PROD_W-1:0]    prod [COLS][COLS];
    logic signed [ACC_WIDTH-1:0] sum  [COLS][COLS];

    // Column count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_in_use <= CFG_COLS_RESET;
        end else if (i_cfg_we) begin
            r_cols_in_use <= i_cfg_data;
        end
    end

    // Stall the whole pipe while a last row waits for the snapshot buffer
    assign pipe_en    = !(prod_ctl.valid && prod_ctl.last && emit_busy);
    assign snap_load  = pipe_en && prod_ctl.valid && prod_ctl.last;
    assign o_in_ready = pipe_en;

    mcpa_mul #(
        .COLS (COLS)
    ) u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_ctl      (prod_ctl),
        .o_prod     (prod)
    );

    mcpa_acc #(
        .COLS      (COLS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_ctl   (prod_ctl),
        .i_prod  (prod),
        .o_sum   (sum)
    );

    mcpa_emit #(
        .COLS      (COLS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (snap_load),
        .i_cols_in_use (r_cols_in_use),
        .i_sum         (sum),
        .i_out_ready   (i_out_ready),
        .o_busy        (emit_busy),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item)
    );

endmodule

// ===== dv/mcpa_checker.sv =====
// Result checker for the cross-product accumulator: mirrors the column-count
// register and the sums, and compares every result transfer in order.
// Depends on mcpa_pkg.
module mcpa_checker
    import mcpa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in_item         i_in_item,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out_item        i_out_item,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int     N_COLS  = 4;
    localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    longint           sums [N_COLS*N_COLS];
    logic [CFG_W-1:0] cols_reg = CFG_COLS_RESET;
    t_out_item        expected_sums [$];
    int               fails = 0;

    // Add one product into a sum, clamping at the signed 48-bit limits
    function automatic longint sat_add(longint acc, longint prod);
        longint s;
        s = acc + prod;
        if (s > SUM_MAX) return SUM_MAX;
        if (s < SUM_MIN) return SUM_MIN;
        return s;
    endfunction

    // Clamp the register to the range 1..N_COLS
    function automatic int used_cols();
        int c;
        c = cols_reg;
        if (c == 0) c = 1;
        if (c > N_COLS) c = N_COLS;
        return c;
    endfunction

    // Fold one row pair into all sums; on the last row queue the matrix and clear
    function automatic void fold_row(t_in_item it);
        longint    xs [N_COLS];
        longint    ys [N_COLS];
        int        n;
        t_out_item r;
        xs[0] = it.x_0;
        xs[1] = it.x_1;
        xs[2] = it.x_2;
        xs[3] = it.x_3;
        ys[0] = it.y_0;
        ys[1] = it.y_1;
        ys[2] = it.y_2;
        ys[3] = it.y_3;
        for (int i = 0; i < N_COLS; i++) begin
            for (int j = 0; j < N_COLS; j++) begin
                sums[i*N_COLS+j] = sat_add(sums[i*N_COLS+j], xs[i] * ys[j]);
            end
        end
        if (!it.last_row) return;
        n = used_cols();
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                r.value   = sums[i*N_COLS+j][VALUE_W-1:0];
                r.out_row = IDX_W'(i);
                r.out_col = IDX_W'(j);
                r.last    = (i == n - 1) && (j == n - 1);
                expected_sums.push_back(r);
            end
        end
        foreach (sums[k]) sums[k] = 0;
    endfunction

    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    initial foreach (sums[k]) sums[k] = 0;

    // Compare result transfers first; a row taken this edge cannot have results yet
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (sums[k]) sums[k] = 0;
            cols_reg = CFG_COLS_RESET;
            expected_sums.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_sums.size() == 0) begin
                    $error("result transfer with no result expected: value %0d",
                           i_out_item.value);
                    fails++;
                end else begin
                    want = expected_sums.pop_front();
                    check_field("value", want.value, i_out_item.value);
                    check_field("out_row", want.out_row, i_out_item.out_row);
                    check_field("out_col", want.out_col, i_out_item.out_col);
                    check_field("last", want.last, i_out_item.last);
                end
            end
            if (i_cfg_we) cols_reg = i_cfg_data;
            if (i_in_valid && i_in_ready) fold_row(i_in_item);
        end
        o_pending    <= expected_sums.size();
        o_fail_count <= fails;
    end

endmodule

// ===== dv/tb.sv =====
// Top of the cross-product accumulator testbench: clock, reset, row stimulus,
// column-count writes, output back-pressure, watchdog and verdict.
// Depends on mcpa_pkg, matrix_cross_product_accumulator and mcpa_checker.
module tb;
    import mcpa_pkg::*;

    localparam int RAND_ROWS    = 150;
    localparam int SAT_ROWS     = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;

    localparam logic signed [ELEM_W-1:0] E_MIN = 16'sh8000;
    localparam logic signed [ELEM_W-1:0] E_MAX = 16'sh7FFF;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_item         in_item   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_item;

    int fail_count;
    int pending;
    int send_idle_pct = 29;
    int recv_idle_pct = 63;
    int stall_cycles  = 0;

    matrix_cross_product_accumulator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    mcpa_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Drop ready at random to stall the result side
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run when no transfer happens for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_in_item make_row(
        logic signed [ELEM_W-1:0] x0, logic signed [ELEM_W-1:0] x1,
        logic signed [ELEM_W-1:0] x2, logic signed [ELEM_W-1:0] x3,
        logic signed [ELEM_W-1:0] y0, logic signed [ELEM_W-1:0] y1,
        logic signed [ELEM_W-1:0] y2, logic signed [ELEM_W-1:0] y3,
        logic last);
        t_in_item it;
        it.x_0 = x0;
        it.x_1 = x1;
        it.x_2 = x2;
        it.x_3 = x3;
        it.y_0 = y0;
        it.y_1 = y1;
        it.y_2 = y2;
        it.y_3 = y3;
        it.last_row = last;
        return it;
    endfunction

    // Favor the extremes and zero, otherwise any 16-bit value
    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(7))
            0: return E_MIN;
            1: return E_MAX;
            2: return '0;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_row(logic last);
        return make_row(rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                        rand_elem(), rand_elem(), rand_elem(), rand_elem(), last);
    endfunction

    // Hold valid until the row transfers; idle at random before it
    task automatic send_row(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    // Write the column count once every result is out and the pipe is empty
    task automatic set_cols(input logic [CFG_W-1:0] cols);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= cols;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        int rows_left;
        int seg;
        int mat_left;

        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows, first at the reset column count
        send_row(make_row(E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, 1'b1));
        send_row(make_row(E_MAX, E_MAX, E_MAX, E_MAX, E_MIN, E_MIN, E_MIN, E_MIN, 1'b0));
        send_row(make_row(16'sd1, -16'sd1, 16'sd256, -16'sd256,
                          E_MAX, E_MIN, 16'sd0, 16'sd1, 1'b1));
        // Zero column count acts as one
        set_cols(3'd0);
        send_row(make_row(E_MIN, 16'sd5, 16'sd6, 16'sd7, 16'sd3, 16'sd9, -16'sd2, E_MAX, 1'b1));
        // Oversized column count clamps to four
        set_cols(3'd7);
        send_row(make_row(16'sd100, -16'sd200, 16'sd300, -16'sd400,
                          -16'sd1, 16'sd2, -16'sd3, 16'sd4, 1'b0));
        send_row(make_row(E_MAX, E_MIN, E_MAX, E_MIN, E_MAX, E_MAX, E_MIN, E_MIN, 1'b1));
        set_cols(3'd2);
        send_row(make_row(16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 1'b0));
        send_row(make_row(-16'sd1, -16'sd1, -16'sd1, -16'sd1,
                          16'sd16, 16'sd32, 16'sd64, 16'sd128, 1'b1));
        set_cols(3'd5);
        send_row(make_row(E_MIN, E_MAX, 16'sd0, -16'sd1, -16'sd1, 16'sd0, E_MAX, E_MIN, 1'b1));
        // Change the count in the middle of a matrix
        set_cols(3'd3);
        send_row(make_row(16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd9, 16'sd9, 16'sd9, 16'sd9, 1'b0));
        set_cols(3'd1);
        send_row(make_row(16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 16'sd9, 1'b1));
        set_cols(3'd6);
        send_row(make_row(-16'sd5, 16'sd6, -16'sd7, 16'sd8, 16'sd9, -16'sd10, 16'sd11, -16'sd12,
                          1'b1));

        // Random matrices; segments may end mid-matrix before a count change
        mat_left = 0;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 29; recv_idle_pct = 63; end
                1: begin send_idle_pct = 63; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            rows_left = RAND_ROWS / 3;
            while (rows_left > 0) begin
                set_cols(CFG_W'($urandom_range(7)));
                seg = $urandom_range(8, 24);
                for (int k = 0; k < seg && rows_left > 0; k++) begin
                    if (mat_left == 0) mat_left = $urandom_range(1, 6);
                    mat_left--;
                    send_row(rand_row((mat_left == 0) || ($urandom_range(15) == 0)));
                    rows_left--;
                end
            end
        end

        // Push every sum toward both limits, then back off them
        set_cols(3'd4);
        for (int k = 0; k < SAT_ROWS; k++) begin
            send_row(make_row(E_MIN, E_MIN, E_MAX, E_MAX, E_MIN, E_MAX, E_MIN, E_MAX, 1'b0));
        end
        for (int k = 0; k < 3; k++) begin
            send_row(make_row(E_MAX, E_MAX, E_MIN, E_MIN, E_MIN, E_MAX, E_MIN, E_MAX,
                              k == 2));
        end

        // Drain and give the verdict
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
